>>> hw/rtl/rcfd_pkg.sv
package rcfd_pkg;

  // frame layout
  localparam int NUM_CHANNELS    = 16;
  localparam int CHANNEL_WIDTH   = 11;
  localparam int PAYLOAD_LEN     = 23;
  localparam int CHAN_BYTES      = PAYLOAD_LEN - 1;
  localparam int STATUS_POSITION = PAYLOAD_LEN;
  localparam int END_POSITION    = PAYLOAD_LEN + 1;
  localparam int POS_WIDTH       = $clog2(END_POSITION + 1);
  localparam int ADDR_WIDTH      = $clog2(CHAN_BYTES);
  localparam int INDEX_WIDTH     = $clog2(NUM_CHANNELS);

  // bit accumulator of the unpack unit: fewer than one channel plus one byte
  localparam int ACC_WIDTH = CHANNEL_WIDTH - 1 + 8;
  localparam int CNT_WIDTH = $clog2(ACC_WIDTH + 1);

  // status bits and counter
  localparam int FRAME_LOST_BIT = 3;
  localparam int FAILSAFE_BIT   = 2;
  localparam logic [3:0] COUNT_MAX = 4'd15;

  // configuration port
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 8;
  localparam logic [7:0] START_BYTE_RESET = 8'd15;
  localparam logic [7:0] END_BYTE_RESET   = 8'd0;
  localparam logic [3:0] BAD_LIMIT_RESET  = 4'd10;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_START_BYTE = 2'd0,
    REG_END_BYTE   = 2'd1,
    REG_BAD_LIMIT  = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte;
    logic [3:0] bad_limit;
  } cfg_t;

  typedef struct packed {
    logic                  en;
    logic [ADDR_WIDTH-1:0] addr;
    logic [7:0]            data;
  } ram_wr_t;

  typedef struct packed {
    logic                     valid;
    logic [INDEX_WIDTH-1:0]   index;
    logic [CHANNEL_WIDTH-1:0] value;
    logic                     last;
  } chan_res_t;

  typedef enum logic {
    ST_RX,
    ST_UNPACK
  } top_state_t;

  typedef enum logic [1:0] {
    UP_IDLE,
    UP_READ,
    UP_MERGE,
    UP_EMIT
  } up_state_t;

endpackage

>>> hw/rtl/rcfd_rx_if.sv
interface rcfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

>>> hw/rtl/rcfd_res_if.sv
interface rcfd_res_if import rcfd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [INDEX_WIDTH-1:0]   channel_index;
  logic [CHANNEL_WIDTH-1:0] channel_value;
  logic                     channel_ok;
  logic [7:0]               status_byte;
  logic                     frame_lost;
  logic                     failsafe;
  logic                     bad_connection;
  logic                     last;

  modport source (
    output valid, output channel_index, output channel_value, output channel_ok,
    output status_byte, output frame_lost, output failsafe, output bad_connection,
    output last, input ready
  );
  modport sink (
    input valid, input channel_index, input channel_value, input channel_ok,
    input status_byte, input frame_lost, input failsafe, input bad_connection,
    input last, output ready
  );
endinterface

>>> hw/rtl/rcfd_cfg_if.sv
interface rcfd_cfg_if import rcfd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CFG_INDEX_WIDTH-1:0] index;
  logic [CFG_DATA_WIDTH-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/rcfd_cfg_regs.sv
module rcfd_cfg_regs import rcfd_pkg::*; (
  input  logic clk,
  input  logic rst,
  rcfd_cfg_if.sink cfg,
  output cfg_t regs
);

  // writes are always taken
  assign cfg.ready = 1'b1;

  // register file, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.start_byte <= START_BYTE_RESET;
      regs.end_byte   <= END_BYTE_RESET;
      regs.bad_limit  <= BAD_LIMIT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_START_BYTE: regs.start_byte <= cfg.data[7:0];
        REG_END_BYTE:   regs.end_byte   <= cfg.data[7:0];
        REG_BAD_LIMIT:  regs.bad_limit  <= cfg.data[3:0];
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/rcfd_unpack.sv
module rcfd_unpack import rcfd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  ram_wr_t   wr,
  output chan_res_t res,
  input  logic      res_ready
);

  logic [7:0]             mem [CHAN_BYTES];
  logic [7:0]             rd_data;
  logic [ADDR_WIDTH:0]    rd_addr;
  logic [CNT_WIDTH-1:0]   cnt;
  logic [ACC_WIDTH-1:0]   acc;
  logic [INDEX_WIDTH-1:0] ch;
  up_state_t              state;
  up_state_t              state_next;
  logic                   last_ch;

  assign last_ch = ch == INDEX_WIDTH'(NUM_CHANNELS - 1);

  // payload memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (state == UP_READ) begin
      rd_data <= mem[rd_addr[ADDR_WIDTH-1:0]];
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      UP_IDLE: begin
        if (start) state_next = UP_READ;
      end
      UP_READ: state_next = UP_MERGE;
      UP_MERGE: begin
        if ((cnt + CNT_WIDTH'(8)) >= CNT_WIDTH'(CHANNEL_WIDTH)) state_next = UP_EMIT;
        else state_next = UP_READ;
      end
      UP_EMIT: begin
        if (res_ready) begin
          if (last_ch) state_next = UP_IDLE;
          else if (cnt >= CNT_WIDTH'(2 * CHANNEL_WIDTH)) state_next = UP_EMIT;
          else state_next = UP_READ;
        end
      end
      default: state_next = UP_IDLE;
    endcase
  end

  // result outputs
  always_comb begin
    res.valid = state == UP_EMIT;
    res.index = ch;
    res.value = acc[CHANNEL_WIDTH-1:0];
    res.last  = last_ch;
  end

  // sequencer and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= UP_IDLE;
      rd_addr <= '0;
      cnt     <= '0;
      ch      <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        UP_IDLE: begin
          if (start) begin
            rd_addr <= '0;
            cnt     <= '0;
            ch      <= '0;
          end
        end
        UP_MERGE: begin
          cnt     <= cnt + CNT_WIDTH'(8);
          rd_addr <= rd_addr + (ADDR_WIDTH + 1)'(1);
        end
        UP_EMIT: begin
          if (res_ready) begin
            cnt <= cnt - CNT_WIDTH'(CHANNEL_WIDTH);
            ch  <= ch + INDEX_WIDTH'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // shared shift unit: merge a byte above the held bits, drop a channel below
  always_ff @(posedge clk) begin
    unique case (state)
      UP_IDLE: begin
        if (start) acc <= '0;
      end
      UP_MERGE: acc <= acc | (ACC_WIDTH'(rd_data) << cnt);
      UP_EMIT: begin
        if (res_ready) acc <= acc >> CHANNEL_WIDTH;
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  // a channel is shown only with all of its bits held
  a_emit_full: assert property (@(posedge clk) disable iff (rst)
    state == UP_EMIT |-> cnt >= CNT_WIDTH'(CHANNEL_WIDTH))
    else $error("channel emitted with too few bits");

  // a fetch never overflows the accumulator
  a_read_room: assert property (@(posedge clk) disable iff (rst)
    state == UP_READ |-> cnt < CNT_WIDTH'(CHANNEL_WIDTH))
    else $error("byte fetched with a full channel held");

  // the last channel uses up exactly the channel bytes
  a_last_addr: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.last |-> rd_addr == (ADDR_WIDTH + 1)'(CHAN_BYTES))
    else $error("last channel at wrong byte address");
`endif

endmodule

>>> hw/rtl/serial_rc_frame_decoder.sv
// Serial RC frame decoder. Bytes come in on rx, one transaction per byte. A
// frame whose end byte matches and whose status is nonzero gives one
// status-only result at once; a zero status gives 16 channel results, and
// the block then takes no byte until the last of them is loaded into the
// output register: the shared shift-and-merge unit reads the 22 channel
// bytes from the payload memory one at a time and shows each channel once
// all its bits are held, stalling while res is not ready. A closing byte is
// also held off while the previous result still waits on res. Registers:
// 0 start byte, 1 end byte, 2 bad-frame limit.
module serial_rc_frame_decoder import rcfd_pkg::*; (
  input logic clk,
  input logic rst,
  rcfd_rx_if.sink    rx,
  rcfd_res_if.source res,
  rcfd_cfg_if.sink   cfg
);

  cfg_t                     regs;
  top_state_t               state;
  top_state_t               state_next;
  logic [POS_WIDTH-1:0]     pos;
  logic [7:0]               status_shadow;
  logic [7:0]               last_status;
  logic [3:0]               bad_count;
  logic [3:0]               inc_count;
  logic [3:0]               new_count;
  ram_wr_t                  wr;
  chan_res_t                chan;
  logic                     chan_ready;
  logic                     unpack_start;
  logic                     in_fire;
  logic                     at_end;
  logic                     end_ok;
  logic                     good_frame;
  logic                     bad_frame;
  logic                     load_chan;
  logic                     out_valid;
  logic [INDEX_WIDTH-1:0]   out_index;
  logic [CHANNEL_WIDTH-1:0] out_value;
  logic                     out_ok;
  logic [7:0]               out_status;
  logic                     out_bad;
  logic                     out_last;

  rcfd_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  rcfd_unpack u_unpack (
    .clk       (clk),
    .rst       (rst),
    .start     (unpack_start),
    .wr        (wr),
    .res       (chan),
    .res_ready (chan_ready)
  );

  // frame decode
  assign in_fire    = rx.valid && rx.ready;
  assign at_end     = pos == POS_WIDTH'(END_POSITION);
  assign end_ok     = rx.rx_byte == regs.end_byte;
  assign good_frame = in_fire && at_end && end_ok && (status_shadow == 8'd0);
  assign bad_frame  = in_fire && at_end && end_ok && (status_shadow != 8'd0);
  assign load_chan  = chan.valid && chan_ready;

  // saturating bad-frame counter, clamped to the limit
  always_comb begin
    inc_count = (bad_count < COUNT_MAX) ? bad_count + 4'd1 : COUNT_MAX;
    new_count = (inc_count >= regs.bad_limit) ? regs.bad_limit : inc_count;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_RX: begin
        if (good_frame) state_next = ST_UNPACK;
      end
      ST_UNPACK: begin
        if (load_chan && chan.last) state_next = ST_RX;
      end
      default: state_next = ST_RX;
    endcase
  end

  // control outputs
  always_comb begin
    rx.ready     = (state == ST_RX) && (!at_end || !out_valid);
    chan_ready   = (state == ST_UNPACK) && (!out_valid || res.ready);
    unpack_start = good_frame;
    wr.en        = in_fire && (pos != '0) && (pos < POS_WIDTH'(STATUS_POSITION));
    wr.addr      = ADDR_WIDTH'(pos - POS_WIDTH'(1));
    wr.data      = rx.rx_byte;
  end

  // byte position, status and counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_RX;
      pos         <= '0;
      last_status <= 8'd0;
      bad_count   <= 4'd0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        priority if (pos == '0) begin
          if (rx.rx_byte == regs.start_byte) pos <= POS_WIDTH'(1);
        end else if (at_end) begin
          pos <= '0;
          if (end_ok) begin
            last_status <= status_shadow;
            if (status_shadow == 8'd0) bad_count <= 4'd0;
            else bad_count <= new_count;
          end
        end else begin
          pos <= pos + POS_WIDTH'(1);
        end
      end
    end
  end

  // status slot of the payload
  always_ff @(posedge clk) begin
    if (in_fire && (pos == POS_WIDTH'(STATUS_POSITION))) begin
      status_shadow <= rx.rx_byte;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (bad_frame || load_chan) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (bad_frame) begin
      out_index  <= '0;
      out_value  <= '0;
      out_ok     <= 1'b0;
      out_status <= status_shadow;
      out_bad    <= new_count >= regs.bad_limit;
      out_last   <= 1'b1;
    end else if (load_chan) begin
      out_index  <= chan.index;
      out_value  <= chan.value;
      out_ok     <= 1'b1;
      out_status <= last_status;
      out_bad    <= bad_count >= regs.bad_limit;
      out_last   <= chan.last;
    end
  end

  assign res.valid          = out_valid;
  assign res.channel_index  = out_index;
  assign res.channel_value  = out_value;
  assign res.channel_ok     = out_ok;
  assign res.status_byte    = out_status;
  assign res.frame_lost     = out_status[FRAME_LOST_BIT];
  assign res.failsafe       = out_status[FAILSAFE_BIT];
  assign res.bad_connection = out_bad;
  assign res.last           = out_last;

`ifndef SYNTH
  // a closing byte is taken only with the output register empty
  a_end_empty: assert property (@(posedge clk) disable iff (rst)
    in_fire && at_end |-> !out_valid)
    else $error("closing byte taken over a pending result");

  // a bad-status frame shows its single result next cycle
  a_status_res: assert property (@(posedge clk) disable iff (rst)
    bad_frame |=> res.valid && res.last && !res.channel_ok)
    else $error("status-only result missing");

  // a good frame starts the unpack with the counter cleared
  a_good_start: assert property (@(posedge clk) disable iff (rst)
    good_frame |=> state == ST_UNPACK && bad_count == 4'd0)
    else $error("good frame did not start unpack");

  // unpacking only runs between frames
  a_unpack_pos: assert property (@(posedge clk) disable iff (rst)
    state == ST_UNPACK |-> pos == '0 && !rx.ready)
    else $error("byte position moved during unpack");
`endif

endmodule
